FILE: hw/rtl/ifpc_pkg.sv
// ----------------------------------------------------------------------------
// ifpc_pkg: shared types and constants of the infix to postfix converter
// Character codes, operator codes, priorities and the control structs that
// pass between the sequencer, the operator stack and the output buffer.
// ----------------------------------------------------------------------------
package ifpc_pkg;

    // Characters with a meaning of their own; every other value is an operand.
    localparam logic [7:0] CHAR_LP  = 8'h28;  // (
    localparam logic [7:0] CHAR_RP  = 8'h29;  // )
    localparam logic [7:0] CHAR_MUL = 8'h2A;  // *
    localparam logic [7:0] CHAR_ADD = 8'h2B;  // +
    localparam logic [7:0] CHAR_SUB = 8'h2D;  // -
    localparam logic [7:0] CHAR_DIV = 8'h2F;  // /

    // Operator codes as they are held on the stack.
    typedef logic [2:0] t_code;
    localparam t_code CODE_LP  = 3'd0;
    localparam t_code CODE_ADD = 3'd1;
    localparam t_code CODE_SUB = 3'd2;
    localparam t_code CODE_MUL = 3'd3;
    localparam t_code CODE_DIV = 3'd4;

    typedef logic [1:0] t_prio;
    localparam t_prio PRIO_LP  = 2'd0;
    localparam t_prio PRIO_ADD = 2'd1;
    localparam t_prio PRIO_MUL = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_OVERFLOW = 2'd1;
    localparam t_status STATUS_UNMATCH  = 2'd2;

    typedef enum logic [1:0] {
        KIND_OPERAND = 2'd0,
        KIND_LPAREN  = 2'd1,
        KIND_RPAREN  = 2'd2,
        KIND_OPER    = 2'd3
    } t_kind;

    // Stack commands issued by the sequencer.
    typedef struct packed {
        logic  push;
        logic  pop;
        t_code data;
    } t_stack_ctl;

    // Output buffer commands issued by the sequencer.
    typedef struct packed {
        logic       cand;
        logic [7:0] cand_char;
        logic       finish;
        logic       last;
    } t_ob_ctl;

    // Output buffer handshake back to the sequencer.
    typedef struct packed {
        logic cand_ok;
        logic fin_ok;
    } t_ob_stat;

    function automatic t_kind f_kind(input logic [7:0] ch);
        t_kind k;
        unique case (ch)
            CHAR_LP:                               k = KIND_LPAREN;
            CHAR_RP:                               k = KIND_RPAREN;
            CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV: k = KIND_OPER;
            default:                               k = KIND_OPERAND;
        endcase
        return k;
    endfunction

    function automatic t_code f_code(input logic [7:0] ch);
        t_code c;
        unique case (ch)
            CHAR_ADD: c = CODE_ADD;
            CHAR_SUB: c = CODE_SUB;
            CHAR_MUL: c = CODE_MUL;
            CHAR_DIV: c = CODE_DIV;
            default:  c = CODE_LP;
        endcase
        return c;
    endfunction

    function automatic t_prio f_prio(input t_code c);
        t_prio p;
        unique case (c)
            CODE_MUL, CODE_DIV: p = PRIO_MUL;
            CODE_ADD, CODE_SUB: p = PRIO_ADD;
            default:            p = PRIO_LP;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] f_char(input t_code c);
        logic [7:0] ch;
        unique case (c)
            CODE_LP:  ch = CHAR_LP;
            CODE_ADD: ch = CHAR_ADD;
            CODE_SUB: ch = CHAR_SUB;
            CODE_MUL: ch = CHAR_MUL;
            CODE_DIV: ch = CHAR_DIV;
            default:  ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: hw/rtl/ifpc_if.sv
// ----------------------------------------------------------------------------
// ifpc_in_if / ifpc_out_if: valid-ready channels of the converter
// The input channel carries one infix character, the output channel one
// postfix result.
// ----------------------------------------------------------------------------
interface ifpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_last;

    modport source (output valid, output ch, output is_last, input ready);
    modport sink   (input valid, input ch, input is_last, output ready);
endinterface

interface ifpc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       expr_done;
    logic [1:0] status;

    modport source (output valid, output out_char, output char_valid,
                    output run_last, output expr_done, output status, input ready);
    modport sink   (input valid, input out_char, input char_valid,
                    input run_last, input expr_done, input status, output ready);
endinterface

FILE: hw/rtl/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit: shunting-yard infix to postfix converter
// Takes one infix character per transfer and returns the postfix characters
// that it releases, using a stack of pending operators.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one character and an end-of-expression flag per
// transfer. The output channel gives one result per emitted character; the
// last result of a run has run_last set, and expr_done marks the end of the
// whole expression. An empty result (char_valid low) closes a final
// character or an error that released nothing.
// Timing: after a character is taken, the sequencer emits the stack entries
// it pops one at a time, then pushes, emits an operand, drops the matching
// '(' or finds the stack empty; after the flush of a final character it
// finds the stack empty once more, and it then closes the run. Input ready
// is low meanwhile. The stack's registered top read allows one pop per
// cycle while the output buffer takes results. A result waits in the hold
// stage until the next result or the end of its run is known, and then
// moves to the output register.
// When the receiver stalls, one result waits in the output register and one
// in a hold stage; the sequencer then waits. Reset empties the stack and the
// output at once; the stack memory itself needs no clearing.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ifpc_in_if.sink       i_in,
    ifpc_out_if.source    o_out
);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WORK  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [7:0]          r_ch, n_ch;
    logic                r_last, n_last;
    ifpc_pkg::t_kind     r_kind, n_kind;
    ifpc_pkg::t_code     r_code, n_code;
    ifpc_pkg::t_prio     r_prio, n_prio;
    ifpc_pkg::t_status   r_status, n_status;
    logic [CW-1:0]       r_lp_count, n_lp_count;   // '(' entries on the stack

    ifpc_pkg::t_stack_ctl w_sctl;
    ifpc_pkg::t_ob_ctl    w_octl;
    ifpc_pkg::t_ob_stat   w_ostat;
    logic [CW-1:0]        w_count;
    ifpc_pkg::t_code      w_top;
    logic                 w_empty;
    logic                 w_full;
    logic                 w_accept;
    t_state               w_after;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_empty    = (w_count == '0);
    assign w_full     = (w_count == CW'(STACK_DEPTH));
    // After the character itself is handled, the run either flushes or closes.
    assign w_after    = r_last ? S_FLUSH : S_DONE;

    ifpc_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sctl),
        .o_count (w_count),
        .o_top   (w_top)
    );

    ifpc_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_octl),
        .i_status (r_status),
        .o_stat   (w_ostat),
        .o_out    (o_out)
    );

    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        n_last     = r_last;
        n_kind     = r_kind;
        n_code     = r_code;
        n_prio     = r_prio;
        n_status   = r_status;
        n_lp_count = r_lp_count;

        w_sctl.push      = 1'b0;
        w_sctl.pop       = 1'b0;
        w_sctl.data      = r_code;
        w_octl.cand      = 1'b0;
        w_octl.cand_char = ifpc_pkg::f_char(w_top);
        w_octl.finish    = 1'b0;
        w_octl.last      = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ch     = i_in.ch;
                    n_last   = i_in.is_last;
                    n_kind   = ifpc_pkg::f_kind(i_in.ch);
                    n_code   = ifpc_pkg::f_code(i_in.ch);
                    n_prio   = ifpc_pkg::f_prio(ifpc_pkg::f_code(i_in.ch));
                    n_status = ifpc_pkg::STATUS_OK;
                    // A ')' is unmatched exactly when no '(' waits on the stack.
                    if (n_kind == ifpc_pkg::KIND_RPAREN && r_lp_count == '0) begin
                        n_status = ifpc_pkg::STATUS_UNMATCH;
                    end
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                unique case (r_kind)
                    ifpc_pkg::KIND_OPERAND: begin
                        if (w_ostat.cand_ok) begin
                            w_octl.cand      = 1'b1;
                            w_octl.cand_char = r_ch;
                            n_state          = w_after;
                        end
                    end
                    ifpc_pkg::KIND_LPAREN: begin
                        if (w_full) begin
                            n_status = ifpc_pkg::STATUS_OVERFLOW;
                        end else begin
                            w_sctl.push = 1'b1;
                            n_lp_count  = r_lp_count + CW'(1);
                        end
                        n_state = w_after;
                    end
                    ifpc_pkg::KIND_RPAREN: begin
                        if (w_empty) begin
                            n_state = w_after;
                        end else if (w_top == ifpc_pkg::CODE_LP) begin
                            w_sctl.pop = 1'b1;
                            n_lp_count = r_lp_count - CW'(1);
                            n_state    = w_after;
                        end else if (w_ostat.cand_ok) begin
                            w_sctl.pop  = 1'b1;
                            w_octl.cand = 1'b1;
                        end
                    end
                    default: begin
                        // Operator: pop while the top binds at least as tightly.
                        if (!w_empty && ifpc_pkg::f_prio(w_top) >= r_prio) begin
                            if (w_ostat.cand_ok) begin
                                w_sctl.pop  = 1'b1;
                                w_octl.cand = 1'b1;
                            end
                        end else begin
                            if (w_full) begin
                                n_status = ifpc_pkg::STATUS_OVERFLOW;
                            end else begin
                                w_sctl.push = 1'b1;
                            end
                            n_state = w_after;
                        end
                    end
                endcase
            end
            S_FLUSH: begin
                // End of expression: every entry goes out, '(' included.
                if (w_empty) begin
                    n_state = S_DONE;
                end else if (w_ostat.cand_ok) begin
                    w_sctl.pop  = 1'b1;
                    w_octl.cand = 1'b1;
                    if (w_top == ifpc_pkg::CODE_LP) begin
                        n_lp_count = r_lp_count - CW'(1);
                    end
                end
            end
            S_DONE: begin
                if (w_ostat.fin_ok) begin
                    w_octl.finish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lp_count <= '0;
        end else begin
            r_state    <= n_state;
            r_lp_count <= n_lp_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch     <= n_ch;
        r_last   <= n_last;
        r_kind   <= n_kind;
        r_code   <= n_code;
        r_prio   <= n_prio;
        r_status <= n_status;
    end

    // The stack never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(STACK_DEPTH))
        else $error("operator stack count beyond its depth");

    // The '(' tally can never exceed the number of stacked entries.
    a_lp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lp_count <= w_count)
        else $error("left paren tally exceeds stack count");

    // A taken character blocks the input for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("input ready right after a transfer");

    // At the end of an expression the stack is left empty.
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_last) |-> w_empty)
        else $error("stack not empty at end of expression");
endmodule

FILE: hw/rtl/ifpc_stack.sv
// ----------------------------------------------------------------------------
// ifpc_stack: operator stack
// A memory with one write port and a registered top-of-stack read, kept
// current after every push or pop.
// ----------------------------------------------------------------------------
module ifpc_stack #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ifpc_pkg::t_stack_ctl         i_ctl,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output ifpc_pkg::t_code              o_top
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ifpc_pkg::t_code mem [DEPTH];
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [CW-1:0]   n_top_idx;
    ifpc_pkg::t_code r_top;

    always_comb begin
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CW'(1);
        end
        n_top_idx = n_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // The new top is the pushed code itself, or the entry below after a pop.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_count[AW-1:0]] <= i_ctl.data;
            r_top                <= i_ctl.data;
        end else begin
            r_top <= mem[n_top_idx[AW-1:0]];
        end
    end

    assign o_count = r_count;
    assign o_top   = r_top;
endmodule

FILE: hw/rtl/ifpc_outbuf.sv
// ----------------------------------------------------------------------------
// ifpc_outbuf: result hold stage and output register
// Keeps the newest result back until it is known whether it ends the run,
// then places it in the output register with its end flags.
// ----------------------------------------------------------------------------
module ifpc_outbuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ifpc_pkg::t_ob_ctl     i_ctl,
    input  ifpc_pkg::t_status     i_status,
    output ifpc_pkg::t_ob_stat    o_stat,
    ifpc_out_if.source            o_out
);
    logic              r_held_v;
    logic [7:0]        r_held_char;
    logic              r_out_v;
    logic [7:0]        r_out_char;
    logic              r_out_cv;
    logic              r_out_rl;
    logic              r_out_ed;
    ifpc_pkg::t_status r_out_st;
    logic              w_can;
    logic              w_need_empty;
    logic              w_load;

    assign w_can        = !r_out_v || o_out.ready;
    assign w_need_empty = !r_held_v && (i_ctl.last || i_status != ifpc_pkg::STATUS_OK);
    assign w_load       = (i_ctl.cand && r_held_v)
                        || (i_ctl.finish && (r_held_v || w_need_empty));

    assign o_stat.cand_ok = !r_held_v || w_can;
    assign o_stat.fin_ok  = w_can;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_ctl.cand) begin
                r_held_v <= 1'b1;
            end else if (i_ctl.finish) begin
                r_held_v <= 1'b0;
            end
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cand) begin
            r_held_char <= i_ctl.cand_char;
        end
        if (w_load) begin
            r_out_char <= r_held_v ? r_held_char : 8'h00;
            r_out_cv   <= r_held_v;
            r_out_rl   <= i_ctl.finish;
            r_out_ed   <= i_ctl.finish && i_ctl.last;
            r_out_st   <= i_status;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.out_char   = r_out_char;
    assign o_out.char_valid = r_out_cv;
    assign o_out.run_last   = r_out_rl;
    assign o_out.expr_done  = r_out_ed;
    assign o_out.status     = r_out_st;
endmodule
